[design/btlv_pkg.sv]
// shared types and constants for the ber tlv stream parser
package btlv_pkg;

    // identifier octet mask and queue sizing
    localparam logic [4:0] TAG_LOW_MASK  = 5'h1F;
    localparam int         QUEUE_DEPTH   = 2;
    localparam int         QUEUE_ADDR_W  = $clog2(QUEUE_DEPTH);
    localparam int         QUEUE_COUNT_W = $clog2(QUEUE_DEPTH + 1);

    // parse phase of the back end
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TAG_HIGH,
        PH_LEN_FIRST,
        PH_LEN_LONG,
        PH_VALUE,
        PH_DROP_IND,
        PH_DROP_OVF
    } phase_t;

    // error codes reported with each result
    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_TRUNC_TAG   = 3'd1,
        ERR_TRUNC_LEN   = 3'd2,
        ERR_INDEFINITE  = 3'd3,
        ERR_LEN_OVF     = 3'd4,
        ERR_TRUNC_VALUE = 3'd5
    } err_code_t;

    // classified input byte handed from front to back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
        logic       id_high;
        logic       bit7;
        logic       low7_zero;
    } btlv_token_t;

    // one result item
    typedef struct packed {
        logic        header_valid;
        logic [1:0]  id_class;
        logic        constructed;
        logic [31:0] tag_value;
        logic [31:0] value_length;
        logic        value_valid;
        logic [7:0]  value_byte;
        logic        tlv_end;
        logic [2:0]  error_code;
        logic        buffer_end;
    } btlv_result_t;

endpackage

[design/btlv_if.sv]
// byte input and result output channel interfaces

// input channel: one encoded byte per item
interface btlv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       buffer_last;

    modport source (output valid, output data_byte, output buffer_last, input ready);
    modport sink   (input valid, input data_byte, input buffer_last, output ready);
endinterface

// output channel: one parse result per item
interface btlv_out_if;
    logic        valid;
    logic        ready;
    logic        header_valid;
    logic [1:0]  id_class;
    logic        constructed;
    logic [31:0] tag_value;
    logic [31:0] value_length;
    logic        value_valid;
    logic [7:0]  value_byte;
    logic        tlv_end;
    logic [2:0]  error_code;
    logic        buffer_end;

    modport source (
        output valid, input ready,
        output header_valid, output id_class, output constructed, output tag_value,
        output value_length, output value_valid, output value_byte, output tlv_end,
        output error_code, output buffer_end
    );
    modport sink (
        input valid, output ready,
        input header_valid, input id_class, input constructed, input tag_value,
        input value_length, input value_valid, input value_byte, input tlv_end,
        input error_code, input buffer_end
    );
endinterface

[design/ber_tlv_stream_parser.sv]
// top level of the ber tlv stream parser
// Parses a stream of BER bytes, one byte per input item with the final byte of each
// buffer marked, and returns exactly one result item per byte: the decoded header
// (class, constructed bit, tag, definite length) on the byte that completes it, each
// content byte passed through, the end of each TLV, and an error code with the buffer
// end. The block takes one byte every clock cycle while the queue has room; a byte is
// classified on entry, held in a two-entry queue and run through the parse state
// machine into an output register, so its result is held first in a queue slot and
// then in the output register. Stalls on the output back up through the queue to the
// input ready. LEN_WIDTH sets the width of the length accumulator and content counter
// (16 to 64 bits); longer lengths are flagged as overflow and value_length reports the
// low 32 bits.
module ber_tlv_stream_parser #(
    parameter int LEN_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    btlv_in_if.sink    in_item,
    btlv_out_if.source out_item
);
    import btlv_pkg::*;

    logic         push;
    logic         queue_full;
    logic         tok_valid;
    logic         tok_pop;
    btlv_token_t  push_token;
    btlv_token_t  tok;
    logic         res_valid;
    btlv_result_t res;

    // byte intake and classification
    btlv_front u_front (
        .in_item    (in_item),
        .queue_full (queue_full),
        .push       (push),
        .token      (push_token)
    );

    // decoupling queue
    btlv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_token),
        .full      (queue_full),
        .pop       (tok_pop),
        .pop_valid (tok_valid),
        .pop_data  (tok)
    );

    // parse engine
    btlv_back #(
        .LEN_WIDTH (LEN_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .tok       (tok),
        .tok_pop   (tok_pop),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (out_item.ready)
    );

    // result channel
    assign out_item.valid        = res_valid;
    assign out_item.header_valid = res.header_valid;
    assign out_item.id_class     = res.id_class;
    assign out_item.constructed  = res.constructed;
    assign out_item.tag_value    = res.tag_value;
    assign out_item.value_length = res.value_length;
    assign out_item.value_valid  = res.value_valid;
    assign out_item.value_byte   = res.value_byte;
    assign out_item.tlv_end      = res.tlv_end;
    assign out_item.error_code   = res.error_code;
    assign out_item.buffer_end   = res.buffer_end;

    // a byte is never both header completion and content
    a_hdr_value_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_item.valid |-> !(out_item.header_valid && out_item.value_valid))
        else $error("header and content reported on the same item");

    // tlv end only on a header or content byte
    a_end_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_item.valid && out_item.tlv_end)
            |-> (out_item.header_valid || out_item.value_valid))
        else $error("tlv end without header or content");

    // truncation errors only at the buffer end
    a_trunc_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_item.valid && (out_item.error_code == ERR_TRUNC_TAG
            || out_item.error_code == ERR_TRUNC_LEN
            || out_item.error_code == ERR_TRUNC_VALUE))
            |-> out_item.buffer_end)
        else $error("truncation error away from buffer end");

    // content bytes never carry a header or drop error
    a_value_err: assert property (@(posedge clk) disable iff (!rst_n)
        (out_item.valid && out_item.value_valid)
            |-> (out_item.error_code == ERR_NONE
                || out_item.error_code == ERR_TRUNC_VALUE))
        else $error("content item with unexpected error code");

endmodule

[design/btlv_front.sv]
// front end: accepts input bytes and classifies them for the parser
module btlv_front (
    btlv_in_if.sink              in_item,
    input  logic                 queue_full,
    output logic                 push,
    output btlv_pkg::btlv_token_t token
);
    import btlv_pkg::*;

    // accept whenever the queue has room
    assign in_item.ready = !queue_full;
    assign push          = in_item.valid && !queue_full;

    // byte classification
    always_comb
    begin
        token.data_byte = in_item.data_byte;
        token.last      = in_item.buffer_last;
        token.id_high   = (in_item.data_byte[4:0] == TAG_LOW_MASK);
        token.bit7      = in_item.data_byte[7];
        token.low7_zero = (in_item.data_byte[6:0] == 7'd0);
    end

endmodule

[design/btlv_queue.sv]
// short queue of classified bytes between front and back
module btlv_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  btlv_pkg::btlv_token_t push_data,
    output logic                  full,
    input  logic                  pop,
    output logic                  pop_valid,
    output btlv_pkg::btlv_token_t pop_data
);
    import btlv_pkg::*;

    btlv_token_t               slot_reg [QUEUE_DEPTH];
    logic [QUEUE_ADDR_W-1:0]   wr_ptr_reg;
    logic [QUEUE_ADDR_W-1:0]   wr_ptr_next;
    logic [QUEUE_ADDR_W-1:0]   rd_ptr_reg;
    logic [QUEUE_ADDR_W-1:0]   rd_ptr_next;
    logic [QUEUE_COUNT_W-1:0]  count_reg;
    logic [QUEUE_COUNT_W-1:0]  count_next;
    logic                      do_push;
    logic                      do_pop;

    assign full      = (count_reg == QUEUE_COUNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_ADDR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QUEUE_ADDR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_ADDR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QUEUE_ADDR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QUEUE_COUNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QUEUE_COUNT_W'(1);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[design/btlv_back.sv]
// back end: tlv parse state machine with registered result
module btlv_back #(
    parameter int LEN_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   tok_valid,
    input  btlv_pkg::btlv_token_t  tok,
    output logic                   tok_pop,
    output logic                   res_valid,
    output btlv_pkg::btlv_result_t res,
    input  logic                   res_ready
);
    import btlv_pkg::*;

    phase_t                 phase_reg;
    phase_t                 phase_next;
    phase_t                 phase_mid;
    logic [1:0]             held_class_reg;
    logic [1:0]             held_class_next;
    logic                   held_constructed_reg;
    logic                   held_constructed_next;
    logic [31:0]            tag_accum_reg;
    logic [31:0]            tag_accum_next;
    logic [LEN_WIDTH-1:0]   length_accum_reg;
    logic [LEN_WIDTH-1:0]   length_accum_next;
    logic [6:0]             octets_left_reg;
    logic [6:0]             octets_left_next;
    logic [LEN_WIDTH-1:0]   content_left_reg;
    logic [LEN_WIDTH-1:0]   content_left_next;
    logic                   res_valid_reg;
    logic                   res_valid_next;
    btlv_result_t           res_reg;
    btlv_result_t           res_next;

    logic [LEN_WIDTH-1:0]   len_short;
    logic [LEN_WIDTH-1:0]   len_shift;
    logic [LEN_WIDTH-1:0]   length_new;
    logic [31:0]            len_low;
    logic                   len_overflow;
    logic [6:0]             octets_dec;
    logic                   hdr_done;
    logic                   content_done;
    err_code_t              err;

    // consume a byte when the result register is free or being drained
    assign tok_pop   = tok_valid && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // length arithmetic
    assign len_short    = LEN_WIDTH'(tok.data_byte);
    assign len_shift    = {length_accum_reg[LEN_WIDTH-9:0], tok.data_byte};
    assign len_overflow = |length_accum_reg[LEN_WIDTH-1:LEN_WIDTH-8];
    assign octets_dec   = octets_left_reg - 7'd1;
    assign length_new   = (phase_reg == PH_LEN_FIRST) ? len_short : len_shift;
    assign hdr_done     = ((phase_reg == PH_LEN_FIRST) && !tok.bit7)
                       || ((phase_reg == PH_LEN_LONG) && !len_overflow && (octets_dec == 7'd0));
    assign content_done = (content_left_reg == LEN_WIDTH'(1));

    // reported length carries the low 32 bits
    generate
        if (LEN_WIDTH >= 32)
        begin : g_len_wide
            assign len_low = length_new[31:0];
        end
        else
        begin : g_len_narrow
            assign len_low = {{(32 - LEN_WIDTH){1'b0}}, length_new};
        end
    endgenerate

    // next phase
    always_comb
    begin
        phase_mid = phase_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                phase_mid = tok.id_high ? PH_TAG_HIGH : PH_LEN_FIRST;
            end
            PH_TAG_HIGH:
            begin
                if (!tok.bit7)
                begin
                    phase_mid = PH_LEN_FIRST;
                end
            end
            PH_LEN_FIRST:
            begin
                if (!tok.bit7)
                begin
                    phase_mid = (len_short == '0) ? PH_IDLE : PH_VALUE;
                end
                else if (tok.low7_zero)
                begin
                    phase_mid = PH_DROP_IND;
                end
                else
                begin
                    phase_mid = PH_LEN_LONG;
                end
            end
            PH_LEN_LONG:
            begin
                if (len_overflow)
                begin
                    phase_mid = PH_DROP_OVF;
                end
                else if (octets_dec == 7'd0)
                begin
                    phase_mid = (len_shift == '0) ? PH_IDLE : PH_VALUE;
                end
            end
            PH_VALUE:
            begin
                if (content_done)
                begin
                    phase_mid = PH_IDLE;
                end
            end
            PH_DROP_IND,
            PH_DROP_OVF:
            begin
                phase_mid = phase_reg;
            end
            default:
            begin
                phase_mid = PH_IDLE;
            end
        endcase
        phase_next = phase_reg;
        if (tok_pop)
        begin
            phase_next = tok.last ? PH_IDLE : phase_mid;
        end
    end

    // error code for this byte
    always_comb
    begin
        err = ERR_NONE;
        if (phase_mid == PH_DROP_IND)
        begin
            err = ERR_INDEFINITE;
        end
        else if (phase_mid == PH_DROP_OVF)
        begin
            err = ERR_LEN_OVF;
        end
        else if (tok.last)
        begin
            if (phase_mid == PH_TAG_HIGH)
            begin
                err = ERR_TRUNC_TAG;
            end
            else if ((phase_mid == PH_LEN_FIRST) || (phase_mid == PH_LEN_LONG))
            begin
                err = ERR_TRUNC_LEN;
            end
            else if (phase_mid == PH_VALUE)
            begin
                err = ERR_TRUNC_VALUE;
            end
        end
    end

    // accumulators and result
    always_comb
    begin
        held_class_next       = held_class_reg;
        held_constructed_next = held_constructed_reg;
        tag_accum_next        = tag_accum_reg;
        length_accum_next     = length_accum_reg;
        octets_left_next      = octets_left_reg;
        content_left_next     = content_left_reg;
        res_next              = res_reg;
        res_valid_next        = res_valid_reg && !res_ready;

        if (tok_pop)
        begin
            res_valid_next = 1'b1;
            res_next       = '0;

            // identifier
            if (phase_reg == PH_IDLE)
            begin
                held_class_next       = tok.data_byte[7:6];
                held_constructed_next = tok.data_byte[5];
                tag_accum_next        = tok.id_high ? 32'd0 : {27'd0, tok.data_byte[4:0]};
            end
            if (phase_reg == PH_TAG_HIGH)
            begin
                tag_accum_next = {tag_accum_reg[24:0], tok.data_byte[6:0]};
            end

            // length octets
            if (phase_reg == PH_LEN_FIRST)
            begin
                length_accum_next = tok.bit7 ? '0 : len_short;
                if (tok.bit7)
                begin
                    octets_left_next = tok.data_byte[6:0];
                end
            end
            if ((phase_reg == PH_LEN_LONG) && !len_overflow)
            begin
                length_accum_next = len_shift;
                octets_left_next  = octets_dec;
            end

            // header report
            if (hdr_done)
            begin
                res_next.header_valid = 1'b1;
                res_next.id_class     = held_class_reg;
                res_next.constructed  = held_constructed_reg;
                res_next.tag_value    = tag_accum_reg;
                res_next.value_length = len_low;
                res_next.tlv_end      = (length_new == '0);
                content_left_next     = length_new;
            end

            // content pass-through
            if (phase_reg == PH_VALUE)
            begin
                res_next.value_valid = 1'b1;
                res_next.value_byte  = tok.data_byte;
                res_next.tlv_end     = content_done;
                content_left_next    = content_left_reg - LEN_WIDTH'(1);
            end

            res_next.error_code = err;
            res_next.buffer_end = tok.last;
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= PH_IDLE;
            held_class_reg       <= '0;
            held_constructed_reg <= 1'b0;
            tag_accum_reg        <= '0;
            length_accum_reg     <= '0;
            octets_left_reg      <= '0;
            content_left_reg     <= '0;
            res_valid_reg        <= 1'b0;
        end
        else
        begin
            phase_reg            <= phase_next;
            held_class_reg       <= held_class_next;
            held_constructed_reg <= held_constructed_next;
            tag_accum_reg        <= tag_accum_next;
            length_accum_reg     <= length_accum_next;
            octets_left_reg      <= octets_left_next;
            content_left_reg     <= content_left_next;
            res_valid_reg        <= res_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

[dv/testbench.sv]
// testbench for the ber tlv stream parser: directed and random byte buffers checked by a model
`timescale 1ns / 1ps

module testbench;
    import btlv_pkg::*;

    localparam int LEN_W = 32;

    logic clk;
    logic rst_n;

    btlv_in_if  in_ch ();
    btlv_out_if out_ch ();

    ber_tlv_stream_parser #(
        .LEN_WIDTH(LEN_W)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_item (in_ch),
        .out_item(out_ch)
    );

    // parser model state
    phase_t           parse_phase     = PH_IDLE;
    logic [1:0]       cur_class       = '0;
    logic             cur_constructed = 1'b0;
    logic [31:0]      tag_sum         = '0;
    logic [LEN_W-1:0] len_sum         = '0;
    logic [6:0]       len_todo        = '0;
    logic [LEN_W-1:0] owed            = '0;

    btlv_result_t results_due[$];
    logic [7:0]   frame_bytes[$];

    bit calm       = 1'b0;
    int gap_pct    = 0;
    int stall_pct  = 0;
    int sent_items = 0;
    int fail_count = 0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #(5_000_000);
        $display("testbench: done, errors");
        $finish;
    end

    // parse one byte and return the result it causes
    function automatic btlv_result_t decode_byte(input logic [7:0] b, input logic last);
        btlv_result_t r;
        logic         hdr;
        r   = '0;
        hdr = 1'b0;
        case (parse_phase)
            PH_IDLE:
            begin
                cur_class       = b[7:6];
                cur_constructed = b[5];
                if (b[4:0] == TAG_LOW_MASK)
                begin
                    tag_sum     = '0;
                    parse_phase = PH_TAG_HIGH;
                end
                else
                begin
                    tag_sum     = 32'(b[4:0]);
                    parse_phase = PH_LEN_FIRST;
                end
            end
            PH_TAG_HIGH:
            begin
                // base-128, wraps at 32 bits
                tag_sum = {tag_sum[24:0], b[6:0]};
                if (!b[7])
                    parse_phase = PH_LEN_FIRST;
            end
            PH_LEN_FIRST:
            begin
                len_sum = '0;
                if (!b[7])
                begin
                    len_sum = LEN_W'(b);
                    hdr     = 1'b1;
                end
                else if (b[6:0] == 7'd0)
                    parse_phase = PH_DROP_IND;
                else
                begin
                    len_todo    = b[6:0];
                    parse_phase = PH_LEN_LONG;
                end
            end
            PH_LEN_LONG:
            begin
                // no room for another octet
                if (len_sum[LEN_W-1 -: 8] != 8'd0)
                    parse_phase = PH_DROP_OVF;
                else
                begin
                    len_sum  = {len_sum[LEN_W-9:0], b};
                    len_todo = len_todo - 7'd1;
                    if (len_todo == 7'd0)
                        hdr = 1'b1;
                end
            end
            PH_VALUE:
            begin
                r.value_valid = 1'b1;
                r.value_byte  = b;
                owed          = owed - LEN_W'(1);
                if (owed == '0)
                begin
                    r.tlv_end   = 1'b1;
                    parse_phase = PH_IDLE;
                end
            end
            default: ;
        endcase

        // header complete
        if (hdr)
        begin
            r.header_valid = 1'b1;
            r.id_class     = cur_class;
            r.constructed  = cur_constructed;
            r.tag_value    = tag_sum;
            r.value_length = len_sum[31:0];
            if (len_sum == '0)
            begin
                r.tlv_end   = 1'b1;
                parse_phase = PH_IDLE;
            end
            else
            begin
                owed        = len_sum;
                parse_phase = PH_VALUE;
            end
        end

        if (parse_phase == PH_DROP_IND)
            r.error_code = ERR_INDEFINITE;
        else if (parse_phase == PH_DROP_OVF)
            r.error_code = ERR_LEN_OVF;

        // buffer end: truncation codes and back to idle
        if (last)
        begin
            if (r.error_code == ERR_NONE)
            begin
                if (parse_phase == PH_TAG_HIGH)
                    r.error_code = ERR_TRUNC_TAG;
                else if (parse_phase == PH_LEN_FIRST || parse_phase == PH_LEN_LONG)
                    r.error_code = ERR_TRUNC_LEN;
                else if (parse_phase == PH_VALUE)
                    r.error_code = ERR_TRUNC_VALUE;
            end
            parse_phase  = PH_IDLE;
            r.buffer_end = 1'b1;
        end
        return r;
    endfunction

    // failure note, first ten printed
    task automatic report(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
            report($sformatf("%s expected %h, got %h", name, want, got));
    endtask

    // result checker
    always @(posedge clk)
    begin : check_results
        btlv_result_t want;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (results_due.size() == 0)
                report("result item with no byte pending");
            else
            begin
                want = results_due.pop_front();
                compare_field("header_valid", 32'(want.header_valid),
                              32'(out_ch.header_valid));
                compare_field("id_class", 32'(want.id_class), 32'(out_ch.id_class));
                compare_field("constructed", 32'(want.constructed),
                              32'(out_ch.constructed));
                compare_field("tag_value", want.tag_value, out_ch.tag_value);
                compare_field("value_length", want.value_length, out_ch.value_length);
                compare_field("value_valid", 32'(want.value_valid),
                              32'(out_ch.value_valid));
                compare_field("value_byte", 32'(want.value_byte), 32'(out_ch.value_byte));
                compare_field("tlv_end", 32'(want.tlv_end), 32'(out_ch.tlv_end));
                compare_field("error_code", 32'(want.error_code), 32'(out_ch.error_code));
                compare_field("buffer_end", 32'(want.buffer_end), 32'(out_ch.buffer_end));
            end
        end
    end

    // output stalls in random bursts
    initial
    begin
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(1, 100) <= stall_pct)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    // send one byte item, then maybe a gap
    task automatic send_byte(input logic [7:0] b, input logic last);
        in_ch.valid       <= 1'b1;
        in_ch.data_byte   <= b;
        in_ch.buffer_last <= last;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        results_due = {results_due, decode_byte(b, last)};
        sent_items++;
        @(negedge clk);
        if (!calm && $urandom_range(1, 100) <= gap_pct)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    // hold the input until every result is back
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (results_due.size() != 0);
    endtask

    // add one byte to the end of the frame
    function automatic void put_byte(input logic [7:0] b);
        frame_bytes = {frame_bytes, b};
    endfunction

    // append one well-formed tlv with short content
    function automatic void append_tlv();
        int unsigned tag_octets;
        int unsigned vlen;
        int unsigned nlen;
        logic [7:0]  ident;
        ident = 8'($urandom);
        if ($urandom_range(0, 4) == 0)
        begin
            // high tag number, up to six octets so the tag wraps
            put_byte(ident | 8'h1F);
            tag_octets = $urandom_range(1, 6);
            for (int i = 1; i < tag_octets; i++)
                put_byte(8'h80 | 8'($urandom));
            put_byte(8'($urandom_range(0, 127)));
        end
        else
            put_byte({ident[7:5], 5'($urandom_range(0, 30))});
        vlen = ($urandom_range(0, 29) == 0) ? $urandom_range(100, 127) : $urandom_range(0, 10);
        if ($urandom_range(0, 2) == 0)
        begin
            // long form with leading zero octets
            nlen = $urandom_range(1, 5);
            put_byte(8'h80 | 8'(nlen));
            for (int i = nlen - 1; i >= 0; i--)
                put_byte(8'(vlen >> (8 * i)));
        end
        else
            put_byte(8'(vlen));
        repeat (vlen) put_byte(8'($urandom));
    endfunction

    // append a broken tlv
    function automatic void append_fault();
        put_byte({3'($urandom), 5'($urandom_range(0, 30))});
        case ($urandom_range(0, 3))
            0:
            begin
                // indefinite length
                put_byte(8'h80);
                repeat ($urandom_range(0, 3)) put_byte(8'($urandom));
            end
            1:
            begin
                // more length octets than fit
                put_byte(8'h80 | 8'($urandom_range(5, 8)));
                put_byte(8'($urandom_range(1, 255)));
                repeat ($urandom_range(4, 6)) put_byte(8'($urandom));
            end
            2:
            begin
                // length far past the buffer end
                put_byte(8'h84);
                put_byte(8'($urandom_range(1, 255)));
                repeat ($urandom_range(3, 6)) put_byte(8'($urandom));
            end
            default:
                repeat ($urandom_range(1, 6)) put_byte(8'($urandom));
        endcase
    endfunction

    // high tag, long form with leading zeros, classes 0, 1 and 3, zero length
    task automatic test_header_forms();
        frame_bytes = {8'hDF, 8'h83, 8'h7F, 8'h84, 8'h00, 8'h00, 8'h00, 8'h01, 8'hA5,
                       8'h20, 8'h00, 8'h41, 8'h02, 8'hFF, 8'h00};
        send_frame();
    endtask

    // indefinite length, then overflow on the last byte
    task automatic test_drop_errors();
        frame_bytes = {8'h7E, 8'h80, 8'h55};
        send_frame();
        frame_bytes = {8'h04, 8'h85, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00};
        send_frame();
    endtask

    // buffer ends inside tag, length and content
    task automatic test_truncation();
        frame_bytes = {8'h1F};
        send_frame();
        frame_bytes = {8'h02};
        send_frame();
        frame_bytes = {8'h81, 8'h84, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_frame();
    endtask

    // random buffers with idling on both sides
    task automatic test_random_traffic(input int target);
        sent_items = 0;
        while (sent_items < target)
        begin
            gap_pct   = 15 * $urandom_range(0, 3);
            stall_pct = 15 * $urandom_range(0, 3);
            frame_bytes.delete();
            repeat ($urandom_range(1, 4)) append_tlv();
            case ($urandom_range(0, 9))
                0: append_fault();
                1: frame_bytes = frame_bytes[0:$urandom_range(0, frame_bytes.size() - 2)];
                2: frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] = 8'($urandom);
                default: ;
            endcase
            send_frame();
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end
    endtask

    // full rate, no idling
    task automatic test_back_to_back(input int target);
        wait_drained();
        calm       = 1'b1;
        sent_items = 0;
        while (sent_items < target)
        begin
            frame_bytes.delete();
            repeat ($urandom_range(1, 4)) append_tlv();
            if ($urandom_range(0, 5) == 0)
                append_fault();
            send_frame();
        end
    endtask

    initial
    begin
        int guard;
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.data_byte   = '0;
        in_ch.buffer_last = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_header_forms();
        test_drop_errors();
        test_truncation();
        test_random_traffic(700);
        test_back_to_back(200);

        // let the last results drain
        in_ch.valid <= 1'b0;
        guard = 0;
        do
        begin
            @(negedge clk);
            guard++;
        end
        while (results_due.size() != 0 && guard < 5000);
        repeat (20) @(negedge clk);
        if (results_due.size() != 0)
            report($sformatf("%0d results never arrived", results_due.size()));

        if (fail_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
